// File: rtl/core/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

    localparam int DATA_W          = 32;
    localparam int TOKEN_W         = 8;
    localparam int DEPTH_W         = 7;
    localparam int STATUS_W        = 2;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [TOKEN_W-1:0] TOK_ADD = 8'd43;
    localparam logic [TOKEN_W-1:0] TOK_SUB = 8'd45;
    localparam logic [TOKEN_W-1:0] TOK_MUL = 8'd42;
    localparam logic [TOKEN_W-1:0] TOK_DIV = 8'd47;
    localparam logic [DATA_W-1:0]  DIGIT_BASE = 32'd48;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic               last;
    } token_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic [STATUS_W-1:0]      status;
        logic                     last_out;
    } result_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_PUSH
    } op_t;

    // What each cell loads this cycle
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_UP,
        SH_DOWN
    } shift_t;

    // What the whole row does this cycle
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_COLLAPSE
    } stack_cmd_t;

    function automatic op_t decode_op(input logic [TOKEN_W-1:0] tok);
        op_t op;
        begin
            if (tok == TOK_ADD)
            begin
                op = OP_ADD;
            end
            else if (tok == TOK_SUB)
            begin
                op = OP_SUB;
            end
            else if (tok == TOK_MUL)
            begin
                op = OP_MUL;
            end
            else if (tok == TOK_DIV)
            begin
                op = OP_DIV;
            end
            else
            begin
                op = OP_PUSH;
            end
            return op;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pfe_stream_if.sv
`default_nettype none

interface pfe_stream_if #(
    parameter type payload_t = pfe_pkg::token_t
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pfe_cell.sv
`default_nettype none

module pfe_cell (
    input  wire logic                      clk,
    input  wire pfe_pkg::shift_t           mode,
    input  wire logic [pfe_pkg::DATA_W-1:0] from_up,
    input  wire logic [pfe_pkg::DATA_W-1:0] from_down,
    output logic [pfe_pkg::DATA_W-1:0]      value
);
    import pfe_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        unique case (mode)
            SH_UP:   value_next = from_up;
            SH_DOWN: value_next = from_down;
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: rtl/core/pfe_stack.sv
`default_nettype none

module pfe_stack #(
    parameter int DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire pfe_pkg::stack_cmd_t        cmd,
    input  wire logic [pfe_pkg::DATA_W-1:0] wdata,
    output logic [pfe_pkg::DATA_W-1:0]      top0,
    output logic [pfe_pkg::DATA_W-1:0]      top1
);
    import pfe_pkg::*;

    logic [DATA_W-1:0] cell_val [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            shift_t            mode;
            logic [DATA_W-1:0] up_val;
            logic [DATA_W-1:0] down_val;

            always_comb
            begin
                unique case (cmd)
                    CMD_PUSH:     mode = SH_UP;
                    // top cell takes the result, the rest close the gap
                    CMD_COLLAPSE: mode = (i == 0) ? SH_UP : SH_DOWN;
                    default:      mode = SH_HOLD;
                endcase
            end

            if (i == 0)
            begin : g_head
                assign up_val = wdata;
            end
            else
            begin : g_body
                assign up_val = cell_val[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign down_val = cell_val[i];
            end
            else
            begin : g_inner
                assign down_val = cell_val[i+1];
            end

            pfe_cell u_cell (
                .clk       (clk),
                .mode      (mode),
                .from_up   (up_val),
                .from_down (down_val),
                .value     (cell_val[i])
            );
        end
    endgenerate

    assign top0 = cell_val[0];
    assign top1 = cell_val[1];

endmodule

`default_nettype wire

// File: rtl/core/pfe_divider.sv
`default_nettype none

module pfe_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pfe_pkg::DATA_W-1:0] dividend,
    input  wire logic [pfe_pkg::DATA_W-1:0] divisor,
    output logic                            busy,
    output logic [pfe_pkg::DATA_W-1:0]      quotient
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] md_reg;
    logic [DATA_W-1:0] md_next;
    logic              neg_reg;
    logic              neg_next;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W+1:0] diff;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, md_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        md_next   = md_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            md_next   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // one restoring step: shift in next dividend bit, subtract if it fits
            if (!diff[DATA_W+1])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        md_reg  <= md_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/postfix_expression_evaluator.sv
// Each token beat goes from S_IDLE to S_WB, which loads the result into the output register;
// multiply passes S_MUL first (registered product), divide by a nonzero divisor passes S_DIV
// while the 32-step restoring divider runs. One token is in flight at a time, and the divider
// sets the worst case. The next token is taken while the previous result still waits.
// rst_n (async, active low) empties the stack and the output register; stack
// cells themselves are not cleared.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pfe_stream_if.sink   token_ch,
    pfe_stream_if.source result_ch
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_WB   = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    op_t               op_reg;
    op_t               op_next;
    logic [TOKEN_W-1:0] tok_reg;
    logic [TOKEN_W-1:0] tok_next;
    logic              last_reg;
    logic              last_next;
    logic [DATA_W-1:0] prod_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;
    result_t           out_data_next;

    logic              accept;
    op_t               in_op;
    logic [DATA_W-1:0] top0;
    logic [DATA_W-1:0] top1;
    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic              div_start;
    logic              div_busy;
    logic [DATA_W-1:0] div_quo;
    logic              wb_load;
    logic              full;
    logic [DATA_W-1:0] wb_val;
    logic [STATUS_W-1:0] wb_status;
    logic [CNT_W-1:0]  wb_count;
    logic [DATA_W-1:0] wb_top;
    stack_cmd_t        stack_cmd;

    assign accept = token_ch.valid && token_ch.ready;
    assign in_op  = decode_op(token_ch.data.token);
    assign a_val  = (count_reg != '0) ? top0 : '0;
    assign b_val  = (count_reg > CNT_W'(1)) ? top1 : '0;
    assign full   = (count_reg >= CNT_W'(STACK_DEPTH));

    assign div_start = accept && (in_op == OP_DIV) && (a_val != '0);
    assign wb_load   = (state_reg == S_WB) && (!out_valid_reg || result_ch.ready);

    always_comb
    begin
        wb_status = ST_OK;
        unique case (op_reg)
            OP_ADD: wb_val = b_val + a_val;
            OP_SUB: wb_val = b_val - a_val;
            OP_MUL: wb_val = prod_reg;
            OP_DIV:
            begin
                if (a_val == '0)
                begin
                    wb_val    = '0;
                    wb_status = ST_DIVZERO;
                end
                else
                begin
                    wb_val = div_quo;
                end
            end
            default:
            begin
                wb_val = {{(DATA_W-TOKEN_W){1'b0}}, tok_reg} - DIGIT_BASE;
                if (full)
                begin
                    wb_status = ST_OVERFLOW;
                end
            end
        endcase
    end

    always_comb
    begin
        stack_cmd = CMD_HOLD;
        wb_count  = count_reg;
        wb_top    = wb_val;
        if (op_reg != OP_PUSH)
        begin
            stack_cmd = CMD_COLLAPSE;
            wb_count  = (count_reg > CNT_W'(1)) ? (count_reg - 1'b1) : CNT_W'(1);
        end
        else if (!full)
        begin
            stack_cmd = CMD_PUSH;
            wb_count  = count_reg + 1'b1;
        end
        else
        begin
            // drop the push, report the unchanged top
            wb_top = a_val;
        end
        if (!wb_load)
        begin
            stack_cmd = CMD_HOLD;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        tok_next       = tok_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    tok_next  = token_ch.data.token;
                    last_next = token_ch.data.last;
                    if (in_op == OP_MUL)
                    begin
                        state_next = S_MUL;
                    end
                    else if (div_start)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_WB;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (wb_load)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.top_value = wb_top;
                    out_data_next.depth     = DEPTH_W'(wb_count);
                    out_data_next.status    = wb_status;
                    out_data_next.last_out  = last_reg;
                    count_next = last_reg ? '0 : wb_count;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tok_reg      <= tok_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        prod_reg     <= a_val * b_val;
    end

    pfe_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .cmd   (stack_cmd),
        .wdata (wb_val),
        .top0  (top0),
        .top1  (top1)
    );

    pfe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (b_val),
        .divisor  (a_val),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign token_ch.ready  = (state_reg == S_IDLE);
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV)
        else $error("divider busy outside divide state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        wb_load |-> (!out_valid_reg || result_ch.ready))
        else $error("result register overwritten while held");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_load && last_reg) |=> count_reg == '0)
        else $error("stack not emptied after final token");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("token beat taken without starting work");

endmodule

`default_nettype wire
